@@ hw/rtl/sliding_window_latency_stats_macros.svh @@
// Assertion macros for the sliding window latency statistics block.
// Expects signals named clk and rst_n in the module that uses them.
// Assertion bodies collapse to nothing when SYNTHESIS is defined.
`ifndef SLIDING_WINDOW_LATENCY_STATS_MACROS_SVH
`define SLIDING_WINDOW_LATENCY_STATS_MACROS_SVH
`ifndef SYNTHESIS
`define SWLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWLS_ASSERT_NEVER(lbl, expr, msg) `SWLS_ASSERT(lbl, !(expr), msg)
`else
`define SWLS_ASSERT(lbl, prop, msg)
`define SWLS_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ hw/rtl/swls_pkg.sv @@
// Shared types and constants for the sliding window latency statistics block.
// No dependencies; imported by swls_dp, swls_ctrl and the top module (swls_div does not use it).
package swls_pkg;

  localparam int unsigned WINDOW_DEF  = 1024;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned COUNT_OUT_W = 11;

  localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic record_rd;  // read the slot at the write pointer, latch the sample
    logic update;     // write the sample, adjust sum, count and pointer
    logic clear;      // empty the window
    logic start;      // reset walk index and min/max accumulators
    logic div_start;  // launch the mean division
    logic walk_rd;    // read the next held sample
    logic out_load;   // load the output register
  } swls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic idx_last;
    logic div_done;
    logic out_free;
  } swls_sts_t;

endpackage

@@ hw/rtl/swls_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module swls_div #(
  parameter int unsigned DIVIDEND_W = 42,
  parameter int unsigned DIVISOR_W  = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dq_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W+1:0]  diff;
  logic                  ge;

  assign rem_sh = {rem_r, dq_r[DIVIDEND_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
  assign ge     = ~diff[DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(DIVIDEND_W);
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DIVIDEND_W-2:0], ge};
      rem_r <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

@@ hw/rtl/swls_dp.sv @@
// Datapath: sample ring memory, sum, count, pointer, min/max walk, output register.
// Depends on swls_pkg, swls_div and the assertion macro header.
`include "sliding_window_latency_stats_macros.svh"
module swls_dp #(
  parameter int unsigned WINDOW = swls_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  swls_pkg::swls_cmd_t              cmd,
  output swls_pkg::swls_sts_t              sts,
  input  logic [swls_pkg::SAMPLE_W-1:0]    in_sample_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [swls_pkg::COUNT_OUT_W-1:0] out_sample_count,
  output logic [swls_pkg::SAMPLE_W-1:0]    out_min_latency,
  output logic [swls_pkg::SAMPLE_W-1:0]    out_max_latency,
  output logic [swls_pkg::SAMPLE_W-1:0]    out_mean_latency
);
  import swls_pkg::*;

  localparam int unsigned PTR_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_W + PTR_W;

  logic [SAMPLE_W-1:0] mem [WINDOW];

  logic [PTR_W-1:0]    wptr_r;
  logic [CNT_W-1:0]    count_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] val_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_vld_r;
  logic [PTR_W-1:0]    idx_r;
  logic [SAMPLE_W-1:0] lo_r;
  logic [SAMPLE_W-1:0] hi_r;
  logic                first_r;
  logic                out_valid_r;
  logic [COUNT_OUT_W-1:0] out_count_r;
  logic [SAMPLE_W-1:0] out_min_r;
  logic [SAMPLE_W-1:0] out_max_r;
  logic [SAMPLE_W-1:0] out_mean_r;

  logic                full;
  logic [PTR_W-1:0]    rd_addr;
  logic [SUM_W-1:0]    sum_nxt;
  logic                div_busy;
  logic [SUM_W-1:0]    quotient;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  assign full    = (count_r == CNT_W'(WINDOW));
  assign rd_addr = cmd.record_rd ? wptr_r : idx_r;
  assign sum_nxt = sum_r + SUM_W'(val_r) - (full ? SUM_W'(rd_data_r) : '0);
  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, count_r};

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[wptr_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.record_rd || cmd.walk_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.record_rd) begin
      val_r <= in_sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.clear) begin
      wptr_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.update) begin
      sum_r <= sum_nxt;
      if (!full) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (wptr_r == PTR_W'(WINDOW - 1)) begin
        wptr_r <= '0;
      end else begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
    end
  end

  // Walk the held samples and fold them into min/max.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      first_r  <= 1'b1;
      idx_r    <= '0;
      lo_r     <= '0;
      hi_r     <= '0;
    end else begin
      rd_vld_r <= cmd.walk_rd;
      if (cmd.start) begin
        idx_r   <= '0;
        first_r <= 1'b1;
        lo_r    <= '0;
        hi_r    <= '0;
      end else begin
        if (cmd.walk_rd) begin
          idx_r <= idx_r + PTR_W'(1);
        end
        if (rd_vld_r) begin
          if (first_r) begin
            first_r <= 1'b0;
            lo_r    <= rd_data_r;
            hi_r    <= rd_data_r;
          end else begin
            if (rd_data_r < lo_r) lo_r <= rd_data_r;
            if (rd_data_r > hi_r) hi_r <= rd_data_r;
          end
        end
      end
    end
  end

  swls_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Output register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= cnt_ext[COUNT_OUT_W-1:0];
      out_min_r   <= lo_r;
      out_max_r   <= hi_r;
      out_mean_r  <= sts.count_zero ? '0 : quotient[SAMPLE_W-1:0];
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.idx_last   = (CNT_W'(idx_r) == count_r - CNT_W'(1));
  assign sts.div_done   = ~div_busy;
  assign sts.out_free   = ~out_valid_r | ~out_stall;

  assign out_valid        = out_valid_r;
  assign out_sample_count = out_count_r;
  assign out_min_latency  = out_min_r;
  assign out_max_latency  = out_max_r;
  assign out_mean_latency = out_mean_r;

  `SWLS_ASSERT(a_count_bound, count_r <= CNT_W'(WINDOW), "held count above window size")
  `SWLS_ASSERT(a_ptr_tracks_count, !full |-> (CNT_W'(wptr_r) == count_r), "pointer off count")
  `SWLS_ASSERT(a_min_le_max, !first_r |-> (lo_r <= hi_r), "walk minimum above maximum")
  `SWLS_ASSERT_NEVER(a_walk_empty, cmd.walk_rd && sts.count_zero, "walk on empty window")

endmodule

@@ hw/rtl/swls_ctrl.sv @@
// Controller state machine: sequences record, walk, divide and output load.
// Depends on swls_pkg.
module swls_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swls_pkg::ACTION_W-1:0] in_action,
  input  swls_pkg::swls_sts_t           sts,
  output swls_pkg::swls_cmd_t           cmd
);
  import swls_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RMW   = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } swls_state_t;

  swls_state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_RECORD) begin
            cmd.record_rd = 1'b1;
            state_nxt     = S_RMW;
          end else begin
            // Query and the unused code leave the state alone.
            cmd.clear = (in_action == ACT_CLEAR);
            state_nxt = S_PREP;
          end
        end
      end
      S_RMW: begin
        cmd.update = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.start = 1'b1;
        if (sts.count_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_rd = 1'b1;
        if (sts.idx_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/sliding_window_latency_stats.sv @@
// Sliding window latency statistics: count, min, max and mean over the last
// WINDOW samples. Built from swls_ctrl and swls_dp; uses swls_pkg.
//
// Input channel (in_valid / in_stall): one word per action. Action record
// stores in_sample_value, overwriting the oldest sample once the window is
// full; action clear empties the window; query (and the unused code) only
// reports. A word is taken when in_valid is high and in_stall is low.
// Result channel (out_valid / out_stall): one word per input word carrying
// count, min, max and truncated mean after the action; all zero when empty.
// Words are handled one at a time: in_stall stays high until the word's result
// is loaded. SUM_W = 32 + log2(WINDOW) sum bits (42 at WINDOW = 1024) size the
// mean divider. With a non-empty window the walk over the single memory read
// port and the one-bit-per-cycle mean divider run side by side and set the time
// per word; a record first adds a read-modify-write step; an empty window skips both.
// The result sits in an output register; the next word is accepted while it
// waits, and the block holds in its last step until the receiver takes it.
// Reset (rst_n low, synchronous) empties the window and drops any pending
// result; memory contents are left as they are and a value read from an unwritten slot is never used.
module sliding_window_latency_stats #(
  parameter int unsigned WINDOW = swls_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [swls_pkg::ACTION_W-1:0]    in_action,
  input  logic [swls_pkg::SAMPLE_W-1:0]    in_sample_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [swls_pkg::COUNT_OUT_W-1:0] out_sample_count,
  output logic [swls_pkg::SAMPLE_W-1:0]    out_min_latency,
  output logic [swls_pkg::SAMPLE_W-1:0]    out_max_latency,
  output logic [swls_pkg::SAMPLE_W-1:0]    out_mean_latency
);
  import swls_pkg::*;

  swls_cmd_t cmd;
  swls_sts_t sts;

  // Sequence each word: record read-modify-write, walk, divide, load output.
  swls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the samples, the running sum and the output register.
  swls_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_count (out_sample_count),
    .out_min_latency  (out_min_latency),
    .out_max_latency  (out_max_latency),
    .out_mean_latency (out_mean_latency)
  );

endmodule
